// ===== hdl/ddsm_pkg.sv =====
package ddsm_pkg;

    localparam int SPEED_W  = 8;
    localparam int FACTOR_W = 4;
    localparam int C255_W   = 12;
    localparam int NUM_W    = 20;
    localparam int DEN_W    = 12;
    localparam int CNT_W    = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [2:0] ACT_JOY   = 3'd0;
    localparam logic [2:0] ACT_OBST  = 3'd1;
    localparam logic [2:0] ACT_ROT   = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_WRITE = 3'd4;

    localparam logic [2:0] LVL_NONE  = 3'd0;
    localparam logic [2:0] LVL_1M    = 3'd1;
    localparam logic [2:0] LVL_50CM  = 3'd2;
    localparam logic [2:0] LVL_25CM  = 3'd3;
    localparam logic [2:0] LVL_10CM  = 3'd4;

    localparam logic [1:0] ROT_CCW  = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_STOP = 2'd2;

    localparam logic [1:0] REP_ROT  = 2'd0;
    localparam logic [1:0] REP_FWD  = 2'd1;
    localparam logic [1:0] REP_REV  = 2'd2;
    localparam logic [1:0] REP_NONE = 2'd3;

    localparam logic [7:0] JOY_CENTER = 8'd128;
    localparam logic [7:0] SPEED_MAX  = 8'd255;
    localparam logic [7:0] SPIN_SPEED = 8'd128;
    localparam logic [7:0] REP_VAL_MAX = 8'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_FULL = 4'd10;
    localparam logic [FACTOR_W-1:0] FACTOR_1M   = 4'd8;
    localparam logic [FACTOR_W-1:0] FACTOR_50CM = 4'd5;
    localparam logic [FACTOR_W-1:0] FACTOR_25CM = 4'd2;
    localparam logic [FACTOR_W-1:0] FACTOR_ZERO = 4'd0;

    typedef enum logic [2:0] {
        OP_JOY,
        OP_OBST,
        OP_ROT,
        OP_READ,
        OP_WRITE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [7:0]          joy_x;
        logic [7:0]          joy_y;
        logic [FACTOR_W-1:0] factor;
        logic                keep;
        logic                ramp;
        logic [1:0]          rot;
        logic [1:0]          rep;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } t_state;

    function automatic logic [FACTOR_W-1:0] factor_of_level(input logic [2:0] level);
        logic [FACTOR_W-1:0] f;
        case (level)
            LVL_NONE: f = FACTOR_FULL;
            LVL_1M:   f = FACTOR_1M;
            LVL_50CM: f = FACTOR_50CM;
            LVL_25CM: f = FACTOR_25CM;
            default:  f = FACTOR_ZERO;
        endcase
        return f;
    endfunction

    // f * 255 as a shift and subtract
    function automatic logic [C255_W-1:0] times255(input logic [FACTOR_W-1:0] f);
        return {f, 8'd0} - {8'd0, f};
    endfunction

endpackage

// ===== hdl/ddsm_front.sv =====
module ddsm_front (
    input  logic                 i_in_valid,
    input  logic [2:0]           i_action,
    input  logic [7:0]           i_joy_x,
    input  logic [7:0]           i_joy_y,
    input  logic [2:0]           i_obstacle_level,
    input  logic [1:0]           i_rotate_kind,
    input  logic [7:0]           i_report_value,
    input  ddsm_pkg::t_q_status  i_q_status,
    output logic                 o_in_stall,
    output logic                 o_push,
    output ddsm_pkg::t_cmd       o_cmd
);
    import ddsm_pkg::*;

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid & ~i_q_status.full;

    always_comb begin
        o_cmd.joy_x  = i_joy_x;
        o_cmd.joy_y  = i_joy_y;
        o_cmd.factor = factor_of_level(i_obstacle_level);
        o_cmd.keep   = (i_obstacle_level > LVL_10CM);
        o_cmd.ramp   = (i_obstacle_level != LVL_10CM);
        o_cmd.rot    = i_rotate_kind;
        o_cmd.rep    = i_report_value[1:0];
        case (i_action)
            ACT_JOY:   o_cmd.op = OP_JOY;
            ACT_OBST:  o_cmd.op = OP_OBST;
            ACT_ROT:   o_cmd.op = OP_ROT;
            ACT_READ:  o_cmd.op = OP_READ;
            // drop out-of-range report writes here
            ACT_WRITE: o_cmd.op = (i_report_value <= REP_VAL_MAX) ? OP_WRITE : OP_NOP;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== hdl/ddsm_queue.sv =====
module ddsm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ddsm_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output ddsm_pkg::t_q_status  o_status,
    output ddsm_pkg::t_cmd       o_cmd
);
    import ddsm_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd          = r_mem[r_rd];

endmodule

// ===== hdl/ddsm_back.sv =====
module ddsm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  ddsm_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [ddsm_pkg::SPEED_W-1:0]  o_left_speed,
    output logic [ddsm_pkg::SPEED_W-1:0]  o_right_speed,
    output logic                          o_left_forward,
    output logic                          o_right_forward,
    output logic                          o_ramp_enable,
    output logic [1:0]                    o_report_code,
    output logic [ddsm_pkg::FACTOR_W-1:0] o_factor
);
    import ddsm_pkg::*;

    t_state              r_state, n_state;
    logic [FACTOR_W-1:0] r_factor, n_factor;
    logic [SPEED_W-1:0]  r_lspd, n_lspd, r_rspd, n_rspd;
    logic                r_ldir, n_ldir, r_rdir, n_rdir;
    logic                r_ramp, n_ramp;
    logic                r_pend, n_pend;
    logic [1:0]          r_rep, n_rep;
    logic [1:0]          r_code, n_code;
    logic [SPEED_W-1:0]  r_sl, n_sl, r_sr, n_sr;
    logic                r_side, n_side;
    logic [NUM_W-1:0]    r_rem, n_rem;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [SPEED_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [SPEED_W-1:0]  r_o_ls, n_o_ls, r_o_rs, n_o_rs;
    logic                r_o_lf, n_o_lf, r_o_rf, n_o_rf, r_o_ramp, n_o_ramp;
    logic [1:0]          r_o_code, n_o_code;

    // joystick mixing
    logic               y_fwd, y_rev;
    logic [7:0]         base, d, sub_v, add_v, mix_l, mix_r;
    logic [8:0]         add9;
    logic               fwd;

    // scaling operands
    logic [SPEED_W-1:0] s_op;
    logic [C255_W-1:0]  c255;
    logic [NUM_W-1:0]   num;
    logic [DEN_W:0]     den_sum;
    logic [NUM_W-1:0]   shifted;
    logic               ge;
    logic [SPEED_W-1:0] quo_next;
    logic [SPEED_W-1:0] result;
    logic               write_result;

    always_comb begin
        y_fwd = (i_cmd.joy_y > JOY_CENTER);
        y_rev = (i_cmd.joy_y < JOY_CENTER);
        fwd   = y_fwd;
        if (y_fwd) begin
            base = {i_cmd.joy_y[6:0], 1'b0};
        end else if (y_rev) begin
            base = (i_cmd.joy_y == 8'd0) ? SPEED_MAX : 8'((JOY_CENTER - i_cmd.joy_y) << 1);
        end else begin
            base = 8'd0;
        end
        d     = (i_cmd.joy_x < JOY_CENTER) ? (JOY_CENTER - i_cmd.joy_x)
                                            : (i_cmd.joy_x - JOY_CENTER);
        sub_v = (base >= d) ? (base - d) : 8'd0;
        add9  = {1'b0, base} + {1'b0, d};
        add_v = add9[8] ? SPEED_MAX : add9[7:0];
        if (i_cmd.joy_x < JOY_CENTER) begin
            mix_l = sub_v;
            mix_r = add_v;
        end else begin
            mix_l = add_v;
            mix_r = sub_v;
        end
    end

    always_comb begin
        s_op     = r_side ? r_sr : r_sl;
        c255     = times255(r_factor);
        num      = NUM_W'(s_op) * NUM_W'(c255);
        den_sum  = (DEN_W+1)'(FACTOR_FULL - r_factor) * (DEN_W+1)'(s_op)
                 + (DEN_W+1)'(c255);
        shifted  = NUM_W'(r_den) << r_cnt;
        ge       = (r_rem >= shifted);
        quo_next = r_quo | (ge ? (SPEED_W'(1) << r_cnt) : '0);
    end

    always_comb begin
        n_state     = r_state;
        n_factor    = r_factor;
        n_lspd      = r_lspd;
        n_rspd      = r_rspd;
        n_ldir      = r_ldir;
        n_rdir      = r_rdir;
        n_ramp      = r_ramp;
        n_pend      = r_pend;
        n_rep       = r_rep;
        n_code      = r_code;
        n_sl        = r_sl;
        n_sr        = r_sr;
        n_side      = r_side;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & i_out_stall;
        n_o_ls      = r_o_ls;
        n_o_rs      = r_o_rs;
        n_o_lf      = r_o_lf;
        n_o_rf      = r_o_rf;
        n_o_ramp    = r_o_ramp;
        n_o_code    = r_o_code;
        o_pop        = 1'b0;
        write_result = 1'b0;
        result       = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_code = REP_NONE;
                    n_side = 1'b0;
                    n_state = ST_EMIT;
                    case (i_cmd.op)
                        OP_JOY: begin
                            n_ramp = 1'b1;
                            if ((y_fwd || y_rev) && (r_ldir != fwd || r_rdir != fwd)) begin
                                n_ldir = fwd;
                                n_rdir = fwd;
                                n_pend = 1'b1;
                                n_rep  = fwd ? REP_FWD : REP_REV;
                            end
                            n_sl    = mix_l;
                            n_sr    = mix_r;
                            n_state = ST_PREP;
                        end
                        OP_OBST: begin
                            if (!i_cmd.keep) begin
                                n_factor = i_cmd.factor;
                            end
                            n_ramp  = i_cmd.ramp;
                            n_sl    = r_lspd;
                            n_sr    = r_rspd;
                            n_state = ST_PREP;
                        end
                        OP_ROT: begin
                            n_ramp = 1'b1;
                            n_rep  = REP_ROT;
                            n_lspd = SPIN_SPEED;
                            n_rspd = SPIN_SPEED;
                            case (i_cmd.rot)
                                ROT_CCW: begin
                                    n_ldir = 1'b0;
                                    n_rdir = 1'b1;
                                end
                                ROT_CW: begin
                                    n_ldir = 1'b1;
                                    n_rdir = 1'b0;
                                end
                                ROT_STOP: begin
                                    n_lspd = '0;
                                    n_rspd = '0;
                                end
                                default: begin
                                end
                            endcase
                        end
                        OP_READ: begin
                            if (r_pend) begin
                                n_pend = 1'b0;
                                n_code = r_rep;
                            end
                        end
                        OP_WRITE: begin
                            n_rep = i_cmd.rep;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PREP: begin
                if (s_op == '0 || r_factor == FACTOR_ZERO) begin
                    write_result = 1'b1;
                    result       = '0;
                end else begin
                    n_rem   = num;
                    n_den   = den_sum[DEN_W-1:0];
                    n_quo   = '0;
                    n_cnt   = CNT_W'(SPEED_W - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = ge ? (r_rem - shifted) : r_rem;
                n_quo = quo_next;
                if (r_cnt == '0) begin
                    write_result = 1'b1;
                    result       = quo_next;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_ls      = r_lspd;
                    n_o_rs      = r_rspd;
                    n_o_lf      = r_ldir;
                    n_o_rf      = r_rdir;
                    n_o_ramp    = r_ramp;
                    n_o_code    = r_code;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // store the scaled speed, then move to the other wheel or finish
        if (write_result) begin
            if (r_side) begin
                n_rspd  = result;
                n_state = ST_EMIT;
            end else begin
                n_lspd  = result;
                n_side  = 1'b1;
                n_state = ST_PREP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_factor    <= FACTOR_FULL;
            r_lspd      <= '0;
            r_rspd      <= '0;
            r_ldir      <= 1'b0;
            r_rdir      <= 1'b0;
            r_ramp      <= 1'b0;
            r_pend      <= 1'b0;
            r_rep       <= REP_ROT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_factor    <= n_factor;
            r_lspd      <= n_lspd;
            r_rspd      <= n_rspd;
            r_ldir      <= n_ldir;
            r_rdir      <= n_rdir;
            r_ramp      <= n_ramp;
            r_pend      <= n_pend;
            r_rep       <= n_rep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_sl     <= n_sl;
        r_sr     <= n_sr;
        r_side   <= n_side;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_o_ls   <= n_o_ls;
        r_o_rs   <= n_o_rs;
        r_o_lf   <= n_o_lf;
        r_o_rf   <= n_o_rf;
        r_o_ramp <= n_o_ramp;
        r_o_code <= n_o_code;
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_speed    = r_o_ls;
    assign o_right_speed   = r_o_rs;
    assign o_left_forward  = r_o_lf;
    assign o_right_forward = r_o_rf;
    assign o_ramp_enable   = r_o_ramp;
    assign o_report_code   = r_o_code;
    assign o_factor        = r_factor;

endmodule

// ===== hdl/differential_drive_speed_mixer.sv =====
// Two-wheel drive command mixer.
//
// Input channel (i_in_valid / o_in_stall): one command word per handshake,
// chosen by i_action: joystick, obstacle level, rotation, read of the
// direction report, or write of the report state. A word is taken at a
// rising edge with i_in_valid high and o_in_stall low.
// Output channel (o_out_valid / i_out_stall): exactly one result word per
// command, in command order: stored wheel speeds, directions, ramp flag and
// the report code (3 unless a read finds a pending report).
// Joystick and obstacle words run both wheel speeds through one shared
// restoring divider (a setup step and 8 one-bit steps per wheel; a wheel
// whose speed, or the factor, is zero gets speed zero and skips the 8 steps).
// The engine works on one word at a time and pops the next only once idle.
// A two-word queue lets the input side keep accepting while the divider
// works or a result waits.
// Reset (i_rst_n low, synchronous): queue empty, no result valid, factor
// back to full speed, speeds, directions and flags cleared.
// While i_out_stall is high the result word holds; the engine finishes its
// current word and waits, and the input stalls once the queue fills.
module differential_drive_speed_mixer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_action,
    input  logic [7:0] i_joy_x,
    input  logic [7:0] i_joy_y,
    input  logic [2:0] i_obstacle_level,
    input  logic [1:0] i_rotate_kind,
    input  logic [7:0] i_report_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_left_speed,
    output logic [7:0] o_right_speed,
    output logic       o_left_forward,
    output logic       o_right_forward,
    output logic       o_ramp_enable,
    output logic [1:0] o_report_code
);
    import ddsm_pkg::*;

    logic                push;
    t_cmd                front_cmd;
    t_cmd                q_cmd;
    t_q_status           q_stat;
    logic                pop;
    logic [FACTOR_W-1:0] factor;

    // classify the incoming word and push it
    ddsm_front u_front (
        .i_in_valid       (i_in_valid),
        .i_action         (i_action),
        .i_joy_x          (i_joy_x),
        .i_joy_y          (i_joy_y),
        .i_obstacle_level (i_obstacle_level),
        .i_rotate_kind    (i_rotate_kind),
        .i_report_value   (i_report_value),
        .i_q_status       (q_stat),
        .o_in_stall       (o_in_stall),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    // decouple intake from the divider
    ddsm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_status (q_stat),
        .o_cmd    (q_cmd)
    );

    // execute commands, scale speeds, hold the result word
    ddsm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_stat.valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_left_speed    (o_left_speed),
        .o_right_speed   (o_right_speed),
        .o_left_forward  (o_left_forward),
        .o_right_forward (o_right_forward),
        .o_ramp_enable   (o_ramp_enable),
        .o_report_code   (o_report_code),
        .o_factor        (factor)
    );

    // no result word right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // factor only ever holds one of the table values
    a_factor_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (factor == FACTOR_FULL) || (factor == FACTOR_1M) || (factor == FACTOR_50CM) ||
        (factor == FACTOR_25CM) || (factor == FACTOR_ZERO))
        else $error("illegal speed factor");

    // input stalls only when the queue holds words for the engine
    a_stall_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_stat.valid)
        else $error("input stalled with empty queue");

    // the engine never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.valid)
        else $error("pop from empty queue");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ddsm_pkg::*;

    // Codes the package leaves unnamed: spare actions, the keep-factor level
    // and a spare neighbor, and the spare rotation kind.
    localparam logic [2:0] ACT_RSVD_5 = 3'd5;
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;
    localparam logic [2:0] LVL_KEEP   = 3'd5;
    localparam logic [2:0] LVL_RSVD_7 = 3'd7;
    localparam logic [1:0] ROT_RSVD   = 2'd3;

    localparam int RANDOM_WORDS = 750;
    localparam int MAX_IDLE     = 13;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] joy_x;
        logic [7:0] joy_y;
        logic [2:0] obstacle_level;
        logic [1:0] rotate_kind;
        logic [7:0] report_value;
    } t_drive_cmd;

    typedef struct packed {
        logic [7:0] left_speed;
        logic [7:0] right_speed;
        logic       left_forward;
        logic       right_forward;
        logic       ramp_enable;
        logic [1:0] report_code;
    } t_drive_word;

    // Mirror of the mixer state plus the queue of drive words still owed.
    class drive_scoreboard;
        logic [FACTOR_W-1:0] factor;
        logic [7:0]          left_spd;
        logic [7:0]          right_spd;
        logic                left_fwd;
        logic                right_fwd;
        logic                ramp_on;
        logic                rep_pending;
        logic [1:0]          rep_state;
        t_drive_word         owed_words[$];
        int                  errors;

        function new();
            factor      = FACTOR_FULL;
            left_spd    = '0;
            right_spd   = '0;
            left_fwd    = 1'b0;
            right_fwd   = 1'b0;
            ramp_on     = 1'b0;
            rep_pending = 1'b0;
            rep_state   = REP_ROT;
            errors      = 0;
        endfunction

        // floor(s*255*f / ((10-f)*s + 255*f)), zero when f or s is zero
        function logic [7:0] scaled_speed(input int unsigned s, input int unsigned f);
            int unsigned num;
            int unsigned den;
            if (f == FACTOR_ZERO || s == 0) return 8'd0;
            num = s * SPEED_MAX * f;
            den = (FACTOR_FULL - f) * s + SPEED_MAX * f;
            return 8'(num / den);
        endfunction

        function void point_both(input logic fwd);
            if (left_fwd != fwd || right_fwd != fwd) begin
                left_fwd    = fwd;
                right_fwd   = fwd;
                rep_pending = 1'b1;
                rep_state   = fwd ? REP_FWD : REP_REV;
            end
        endfunction

        function void mix_joystick(input logic [7:0] x, input logic [7:0] y);
            int unsigned xv;
            int unsigned yv;
            int unsigned base;
            int unsigned l;
            int unsigned r;
            int unsigned d;
            xv = x;
            yv = y;
            ramp_on = 1'b1;
            if (yv > JOY_CENTER) begin
                base = (yv - JOY_CENTER) * 2;
                point_both(1'b1);
            end else if (yv < JOY_CENTER) begin
                base = (yv == 0) ? SPEED_MAX : (JOY_CENTER - yv) * 2;
                point_both(1'b0);
            end else begin
                base = 0;
            end
            l = base;
            r = base;
            if (xv < JOY_CENTER) begin
                d = JOY_CENTER - xv;
                l = (l >= d) ? l - d : 0;
                r = (r + d <= SPEED_MAX) ? r + d : SPEED_MAX;
            end else if (xv > JOY_CENTER) begin
                d = xv - JOY_CENTER;
                r = (r >= d) ? r - d : 0;
                l = (l + d <= SPEED_MAX) ? l + d : SPEED_MAX;
            end
            left_spd  = scaled_speed(l, factor);
            right_spd = scaled_speed(r, factor);
        endfunction

        function void note_command(input t_drive_cmd c);
            logic [1:0] code;
            code = REP_NONE;
            case (c.action)
                ACT_JOY: begin
                    mix_joystick(c.joy_x, c.joy_y);
                end
                ACT_OBST: begin
                    case (c.obstacle_level)
                        LVL_NONE: factor = FACTOR_FULL;
                        LVL_1M:   factor = FACTOR_1M;
                        LVL_50CM: factor = FACTOR_50CM;
                        LVL_25CM: factor = FACTOR_25CM;
                        LVL_10CM: factor = FACTOR_ZERO;
                        default:  ;
                    endcase
                    ramp_on   = (c.obstacle_level != LVL_10CM);
                    left_spd  = scaled_speed(left_spd, factor);
                    right_spd = scaled_speed(right_spd, factor);
                end
                ACT_ROT: begin
                    left_spd  = SPIN_SPEED;
                    right_spd = SPIN_SPEED;
                    ramp_on   = 1'b1;
                    case (c.rotate_kind)
                        ROT_CCW: begin
                            left_fwd  = 1'b0;
                            right_fwd = 1'b1;
                        end
                        ROT_CW: begin
                            left_fwd  = 1'b1;
                            right_fwd = 1'b0;
                        end
                        ROT_STOP: begin
                            left_spd  = '0;
                            right_spd = '0;
                        end
                        default: ;
                    endcase
                    rep_state = REP_ROT;
                end
                ACT_READ: begin
                    if (rep_pending) begin
                        rep_pending = 1'b0;
                        code        = rep_state;
                    end
                end
                ACT_WRITE: begin
                    if (c.report_value <= REP_VAL_MAX) rep_state = c.report_value[1:0];
                end
                default: ;
            endcase
            owed_words.push_back({left_spd, right_spd, left_fwd, right_fwd, ramp_on, code});
        endfunction

        function int outstanding();
            return owed_words.size();
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_drive_word got);
            t_drive_word want;
            if (owed_words.size() == 0) begin
                $error("drive word arrived with nothing expected");
                errors++;
                return;
            end
            want = owed_words.pop_front();
            compare_field("left_speed", want.left_speed, got.left_speed);
            compare_field("right_speed", want.right_speed, got.right_speed);
            compare_field("left_forward", 8'(want.left_forward), 8'(got.left_forward));
            compare_field("right_forward", 8'(want.right_forward), 8'(got.right_forward));
            compare_field("ramp_enable", 8'(want.ramp_enable), 8'(got.ramp_enable));
            compare_field("report_code", 8'(want.report_code), 8'(got.report_code));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_action;
    logic [7:0] i_joy_x;
    logic [7:0] i_joy_y;
    logic [2:0] i_obstacle_level;
    logic [1:0] i_rotate_kind;
    logic [7:0] i_report_value;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_left_speed;
    logic [7:0] o_right_speed;
    logic       o_left_forward;
    logic       o_right_forward;
    logic       o_ramp_enable;
    logic [1:0] o_report_code;

    drive_scoreboard sb;
    int              cycle_count;
    // Raised by the sender, taken by the receiver: hold off for a long stretch.
    logic            long_hold_req;

    differential_drive_speed_mixer i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_gap();
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic t_drive_cmd cmd_of(input logic [2:0] act, input logic [7:0] x,
                                          input logic [7:0] y, input logic [2:0] lvl,
                                          input logic [1:0] kind, input logic [7:0] val);
        t_drive_cmd c;
        c.action         = act;
        c.joy_x          = x;
        c.joy_y          = y;
        c.obstacle_level = lvl;
        c.rotate_kind    = kind;
        c.report_value   = val;
        return c;
    endfunction

    // Favor the centre, the ends and the neighbors of the centre.
    function automatic logic [7:0] joy_position();
        case ($urandom_range(0, 9))
            0:       return JOY_CENTER;
            1:       return 8'd0;
            2:       return SPEED_MAX;
            3:       return JOY_CENTER - 8'd1;
            4:       return JOY_CENTER + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly meaningful commands; fields the action ignores carry noise.
    function automatic t_drive_cmd random_cmd();
        t_drive_cmd  c;
        int unsigned pick;
        c.joy_x          = joy_position();
        c.joy_y          = joy_position();
        c.obstacle_level = 3'($urandom_range(0, 7));
        c.rotate_kind    = 2'($urandom_range(0, 3));
        c.report_value   = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 35)      c.action = ACT_JOY;
        else if (pick < 55) c.action = ACT_OBST;
        else if (pick < 67) c.action = ACT_ROT;
        else if (pick < 82) c.action = ACT_READ;
        else if (pick < 95) c.action = ACT_WRITE;
        else                c.action = 3'($urandom_range(ACT_RSVD_5, ACT_RSVD_7));
        return c;
    endfunction

    // Offer one command word after an idle gap and hold it until taken.
    // With no gap, valid stays high straight into the next word.
    task automatic send_word(input t_drive_cmd c, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action         <= c.action;
        i_joy_x          <= c.joy_x;
        i_joy_y          <= c.joy_y;
        i_obstacle_level <= c.obstacle_level;
        i_rotate_kind    <= c.rotate_kind;
        i_report_value   <= c.report_value;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(c);
    endtask

    // Drop valid and hold the input side until every owed word is back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    // Sender: reset, directed words, then random words with pressure points.
    initial begin
        int gap;
        sb               = new();
        long_hold_req    = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_action         = ACT_JOY;
        i_joy_x          = '0;
        i_joy_y          = '0;
        i_obstacle_level = LVL_NONE;
        i_rotate_kind    = ROT_CCW;
        i_report_value   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Read with nothing pending, then centred stick.
        send_word(cmd_of(ACT_READ, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_JOY, 8'd128, 8'd128, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        // Full forward flips both wheels; the report is read once.
        send_word(cmd_of(ACT_JOY, 8'd128, 8'd255, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_READ, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        // Full reverse at y zero with hard left, then nudge forward hard right.
        send_word(cmd_of(ACT_JOY, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_JOY, 8'd255, 8'd129, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        // Step the factor down, mix at reduced factor, keep it, cut it, keep it, restore it.
        send_word(cmd_of(ACT_OBST, 8'd0, 8'd0, LVL_1M, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_OBST, 8'd0, 8'd0, LVL_50CM, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_OBST, 8'd0, 8'd0, LVL_25CM, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_JOY, 8'd255, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_OBST, 8'd0, 8'd0, LVL_KEEP, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_OBST, 8'd0, 8'd0, LVL_10CM, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_OBST, 8'd0, 8'd0, LVL_RSVD_7, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_OBST, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        // Every rotation kind, the spare one included.
        send_word(cmd_of(ACT_ROT, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_ROT, 8'd0, 8'd0, LVL_NONE, ROT_CW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_ROT, 8'd0, 8'd0, LVL_NONE, ROT_RSVD, 8'd0), idle_gap());
        send_word(cmd_of(ACT_ROT, 8'd0, 8'd0, LVL_NONE, ROT_STOP, 8'd0), idle_gap());
        // Out-of-range write is dropped; a good write shows on the next read.
        send_word(cmd_of(ACT_WRITE, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd255), idle_gap());
        send_word(cmd_of(ACT_WRITE, 8'd0, 8'd0, LVL_NONE, ROT_CCW, REP_VAL_MAX), idle_gap());
        send_word(cmd_of(ACT_READ, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_WRITE, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd3), idle_gap());
        // Spare actions change nothing.
        send_word(cmd_of(ACT_RSVD_5, 8'd255, 8'd255, LVL_RSVD_7, ROT_RSVD, 8'd255),
                  idle_gap());
        send_word(cmd_of(ACT_RSVD_6, 8'd0, 8'd0, LVL_NONE, ROT_CCW, 8'd0), idle_gap());
        send_word(cmd_of(ACT_RSVD_7, 8'd170, 8'd85, LVL_50CM, ROT_CW, 8'd170), idle_gap());
        hold_until_drained();

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            // Stall the output for a long stretch while words keep coming
            // back to back, so the queue fills and the input stalls.
            if (k == 250) long_hold_req = 1'b1;
            // Pause the input until the block has emptied.
            if (k == 500) hold_until_drained();
            if ((k % 100) < 15 || (k >= 250 && k < 280)) gap = 0;
            else gap = idle_gap();
            send_word(random_cmd(), gap);
        end
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: stall for a random number of cycles, then take one word.
    // Every 90 words a short run goes through with no stall at all.
    initial begin
        t_drive_word got;
        int          n;
        int          taken;
        i_out_stall = 1'b0;
        taken       = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                n = LONG_HOLD;
            end else if ((taken % 90) < 12) begin
                n = 0;
            end else begin
                n = idle_gap();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = {o_left_speed, o_right_speed, o_left_forward, o_right_forward,
                   o_ramp_enable, o_report_code};
            sb.check_result(got);
            taken++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ddsm_pkg.sv
hdl/ddsm_front.sv
hdl/ddsm_queue.sv
hdl/ddsm_back.sv
hdl/differential_drive_speed_mixer.sv
tb/tb.sv
